@@ hdl/fmpq_pkg.sv @@
// types, constants and codes shared by the fifo / max priority queue block
// depends on nothing; every other file takes names from here by scope
`timescale 1ns / 1ps

package fmpq_pkg;

    // storage depth in cells and derived widths
    localparam int DEPTH  = 64;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DATA_W = 32;

    // action codes of a command
    localparam logic [1:0] ACT_ARRIVE        = 2'd0;
    localparam logic [1:0] ACT_SERVE_OLDEST  = 2'd1;
    localparam logic [1:0] ACT_SERVE_LARGEST = 2'd2;

    // result status codes
    typedef enum logic [1:0] {
        STAT_STORED = 2'd0,
        STAT_SERVED = 2'd1,
        STAT_EMPTY  = 2'd2,
        STAT_FULL   = 2'd3
    } t_status;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    // command transaction
    typedef struct packed {
        logic [1:0]        action;
        logic [DATA_W-1:0] item_value;
    } t_cmd;

    // result transaction
    typedef struct packed {
        logic [DATA_W-1:0] served_number;
        t_status           status;
    } t_result;

    // contents of one cell
    typedef struct packed {
        logic              occ;
        logic [DATA_W-1:0] number;
        logic [DATA_W-1:0] value;
    } t_entry;

    // running best passed from cell to cell
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] number;
        logic [IDX_W-1:0]  pos;
    } t_wave;

    // controls broadcast to every cell
    typedef struct packed {
        logic             write_en;
        logic             shift_en;
        logic [IDX_W-1:0] pick;
    } t_cell_ctl;

endpackage

@@ hdl/fmpq_cell.sv @@
// one storage cell of the queue chain: entry, occupancy and one step of the max wave
// depends on fmpq_pkg
`timescale 1ns / 1ps

module fmpq_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  fmpq_pkg::t_cell_ctl        i_ctl,
    input  logic [fmpq_pkg::IDX_W-1:0] i_index,
    input  logic [fmpq_pkg::DATA_W-1:0] i_new_value,
    input  logic [fmpq_pkg::DATA_W-1:0] i_new_number,
    input  logic                       i_left_occ,
    input  fmpq_pkg::t_entry           i_right,
    input  fmpq_pkg::t_wave            i_wave,
    output fmpq_pkg::t_entry           o_entry,
    output fmpq_pkg::t_wave            o_wave
);

    logic                        r_occ, n_occ;
    logic [fmpq_pkg::DATA_W-1:0] r_number, n_number;
    logic [fmpq_pkg::DATA_W-1:0] r_value, n_value;
    fmpq_pkg::t_wave             r_wave, n_wave;
    logic                        own_wins;

    always_comb begin
        n_occ    = r_occ;
        n_number = r_number;
        n_value  = r_value;
        // first free cell takes an arrival
        if (i_ctl.write_en && !r_occ && i_left_occ) begin
            n_occ    = 1'b1;
            n_number = i_new_number;
            n_value  = i_new_value;
        end else if (i_ctl.shift_en && (i_index >= i_ctl.pick)) begin
            // close the gap left by the served entry
            n_occ    = i_right.occ;
            n_number = i_right.number;
            n_value  = i_right.value;
        end
    end

    // earlier cells win ties, so only a strictly larger value replaces
    assign own_wins = r_occ && ((i_index == '0) || (r_value > i_wave.value));

    always_comb begin
        if (own_wins) begin
            n_wave.value  = r_value;
            n_wave.number = r_number;
            n_wave.pos    = i_index;
        end else begin
            n_wave = i_wave;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_number <= n_number;
        r_value  <= n_value;
        r_wave   <= n_wave;
    end

    assign o_entry.occ    = r_occ;
    assign o_entry.number = r_number;
    assign o_entry.value  = r_value;
    assign o_wave         = r_wave;

endmodule

@@ hdl/fifo_and_max_priority_queue.sv @@
// top level of the fifo / max priority queue: command sequencer over a chain of cells
// depends on fmpq_pkg and fmpq_cell
`timescale 1ns / 1ps

// Queue of up to 64 entries (fmpq_pkg::DEPTH), each an arrival number and a value,
// kept packed in arrival order in a chain of cells. A command is taken when i_start
// is high and o_busy is low; every command gives exactly one result on o_result,
// shown for one cycle with o_valid, and the receiver cannot stall it. Arrival,
// serve-oldest, an empty serve, a full arrival and the unused action code give their
// result in the cycle after the command, and the next command may follow at once.
// Serve-largest keeps o_busy high while the running maximum travels through the
// chain one cell per clock, so the search length is set by the number of cells,
// whatever the fill level. The entry found is then removed and the later cells
// shift down. Arrival numbers start at 1 after reset and wrap modulo 2^32; a full
// arrival does not use a number. Empty, full and unused-code results carry served
// number 0.

module fifo_and_max_priority_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  fmpq_pkg::t_cmd    i_cmd,
    output logic              o_busy,
    output logic              o_valid,
    output fmpq_pkg::t_result o_result
);

    fmpq_pkg::t_state            r_state, n_state;
    logic [fmpq_pkg::IDX_W-1:0]  r_cnt, n_cnt;
    logic [fmpq_pkg::DATA_W-1:0] r_next_number, n_next_number;
    logic                        r_valid, n_valid;
    fmpq_pkg::t_result           r_result, n_result;
    fmpq_pkg::t_cell_ctl         ctl;

    fmpq_pkg::t_entry w_entry [fmpq_pkg::DEPTH];
    fmpq_pkg::t_wave  w_wave  [fmpq_pkg::DEPTH];

    logic full, empty;

    // occupancy is always a prefix of the chain
    assign full  = w_entry[fmpq_pkg::DEPTH-1].occ;
    assign empty = !w_entry[0].occ;

    // chain of cells: entries flow toward cell 0 on a removal, the max wave flows up
    genvar k;
    generate
        for (k = 0; k < fmpq_pkg::DEPTH; k++) begin : g_cell
            fmpq_pkg::t_entry right_entry;
            fmpq_pkg::t_wave  left_wave;
            logic             left_occ;

            if (k == fmpq_pkg::DEPTH - 1) begin : g_last
                assign right_entry = '0;
            end else begin : g_mid
                assign right_entry = w_entry[k+1];
            end

            if (k == 0) begin : g_first
                assign left_wave = '0;
                assign left_occ  = 1'b1;
            end else begin : g_rest
                assign left_wave = w_wave[k-1];
                assign left_occ  = w_entry[k-1].occ;
            end

            fmpq_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (ctl),
                .i_index      (fmpq_pkg::IDX_W'(k)),
                .i_new_value  (i_cmd.item_value),
                .i_new_number (r_next_number),
                .i_left_occ   (left_occ),
                .i_right      (right_entry),
                .i_wave       (left_wave),
                .o_entry      (w_entry[k]),
                .o_wave       (w_wave[k])
            );
        end
    endgenerate

    // next state, cell controls and the result transaction
    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_next_number = r_next_number;
        n_valid       = 1'b0;
        n_result      = r_result;
        ctl           = '0;

        case (r_state)
            fmpq_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_valid                = 1'b1;
                    n_result.served_number = '0;
                    n_result.status        = fmpq_pkg::STAT_EMPTY;
                    case (i_cmd.action)
                        fmpq_pkg::ACT_ARRIVE: begin
                            if (full) begin
                                n_result.status = fmpq_pkg::STAT_FULL;
                            end else begin
                                ctl.write_en           = 1'b1;
                                n_result.served_number = r_next_number;
                                n_result.status        = fmpq_pkg::STAT_STORED;
                                n_next_number          = r_next_number + 1'b1;
                            end
                        end
                        fmpq_pkg::ACT_SERVE_OLDEST: begin
                            if (!empty) begin
                                // head of the chain is the oldest entry
                                ctl.shift_en           = 1'b1;
                                ctl.pick               = '0;
                                n_result.served_number = w_entry[0].number;
                                n_result.status        = fmpq_pkg::STAT_SERVED;
                            end
                        end
                        fmpq_pkg::ACT_SERVE_LARGEST: begin
                            if (!empty) begin
                                // let the wave settle across every cell
                                n_valid = 1'b0;
                                n_state = fmpq_pkg::ST_SCAN;
                                n_cnt   = fmpq_pkg::IDX_W'(fmpq_pkg::DEPTH - 1);
                            end
                        end
                        default: begin
                            // unused code: reported as empty, nothing changes
                        end
                    endcase
                end
            end
            fmpq_pkg::ST_SCAN: begin
                if (r_cnt == '0) begin
                    // last cell now holds the largest entry, earliest on ties
                    ctl.shift_en           = 1'b1;
                    ctl.pick               = w_wave[fmpq_pkg::DEPTH-1].pos;
                    n_valid                = 1'b1;
                    n_result.served_number = w_wave[fmpq_pkg::DEPTH-1].number;
                    n_result.status        = fmpq_pkg::STAT_SERVED;
                    n_state                = fmpq_pkg::ST_IDLE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            default: begin
                n_state = fmpq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= fmpq_pkg::ST_IDLE;
            r_cnt         <= '0;
            r_next_number <= fmpq_pkg::DATA_W'(1);
            r_valid       <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_cnt         <= n_cnt;
            r_next_number <= n_next_number;
            r_valid       <= n_valid;
        end
    end

    // result payload needs no reset
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_busy   = (r_state != fmpq_pkg::ST_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ hdl/fmpq_checker.sv @@
// port-level checks for the fifo / max priority queue, bound to the top level
// depends on fmpq_pkg and fifo_and_max_priority_queue
`timescale 1ns / 1ps

module fmpq_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_start,
    input fmpq_pkg::t_cmd    i_cmd,
    input logic              o_busy,
    input logic              o_valid,
    input fmpq_pkg::t_result o_result
);

    logic accept;
    assign accept = i_start && !o_busy;

    // a result always ends the busy period
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("result shown while busy");

    // commands other than a largest-value serve answer in the next cycle
    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_cmd.action != fmpq_pkg::ACT_SERVE_LARGEST)) |=> (o_valid && !o_busy))
        else $error("single-cycle command gave no result");

    // a largest-value serve holds the block off for the search
    a_largest_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_cmd.action == fmpq_pkg::ACT_SERVE_LARGEST)) |=> (o_valid || o_busy))
        else $error("largest serve neither answered nor busy");

    // error results carry no number
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ((o_result.status == fmpq_pkg::STAT_EMPTY) ||
                     (o_result.status == fmpq_pkg::STAT_FULL)))
        |-> (o_result.served_number == '0))
        else $error("error result with nonzero number");

endmodule

bind fifo_and_max_priority_queue fmpq_checker u_fmpq_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .i_cmd    (i_cmd),
    .o_busy   (o_busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);
